>>> rtl/core/rrld_pkg.sv
// Shared types and constants of the raster run-length line decoder.
package rrld_pkg;

  localparam int unsigned MaxDimensionDefault = 16384;

  localparam logic [7:0] ESC_BYTE = 8'd128;

  localparam logic [1:0] KIND_BYTE     = 2'd0;
  localparam logic [1:0] KIND_CONTINUE = 2'd1;
  localparam logic [1:0] KIND_START    = 2'd2;
  localparam logic [1:0] KIND_UNUSED   = 2'd3;

  localparam logic [1:0] DEPTH_MONO  = 2'd0;
  localparam logic [1:0] DEPTH_INDEX = 2'd1;
  localparam logic [1:0] DEPTH_RGB24 = 2'd2;
  localparam logic [1:0] DEPTH_RGB32 = 2'd3;

  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_DEPTH_MODE   = 3'd2;
  localparam logic [2:0] REG_RLE          = 3'd3;
  localparam logic [2:0] REG_RGB_ORDER    = 3'd4;

  typedef struct packed {
    logic [14:0] image_width;
    logic [14:0] image_height;
    logic [1:0]  depth_mode;
    logic        run_length_coded;
    logic        rgb_order;
  } cfg_t;

  typedef struct packed {
    logic [16:0] line_byte_index;
    logic [14:0] pixel_column;
    logic [14:0] row_index;
    logic [23:0] color_assembly;
    logic [1:0]  byte_in_pixel;
    logic        image_finished;
  } fmt_state_t;

  // One accepted item expands into a burst of results.
  typedef struct packed {
    logic        mono;
    logic [23:0] data;
    logic [3:0]  count;
    logic        row_end;
    logic        image_end;
    logic        run_pending;
    logic        protocol_error;
  } burst_t;

endpackage

>>> rtl/core/raster_rle_line_decoder.sv
// Raster line decoder top level: register port, run-length decoding and state.
//
// Takes one image byte per transfer and gives pixels, after optional escape-128
// run-length decoding and formatting by pixel depth. A new input transfer can be
// taken every cycle unless the output stalls or a burst drains: the run-length
// and row state update in the cycle of the transfer, and the resulting pixels
// land in an output register. Items at 8, 24 and 32 bits per pixel produce one
// result and so sustain one item per cycle when not stalled; a 1-bit item
// yields up to eight pixels, sent one per cycle unless stalled, with input held
// until the last. Each byte of a pending run needs one continue item.
module raster_rle_line_decoder import rrld_pkg::*; #(
  parameter int unsigned MAX_DIMENSION = MaxDimensionDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        pixel_valid_o,
  output logic [23:0] pixel_o,
  output logic        row_end_o,
  output logic        image_end_o,
  output logic        run_pending_o,
  output logic        protocol_error_o,
  output logic        last_o
);

  typedef enum logic [1:0] {
    ESC_IDLE,
    ESC_SEEN,
    ESC_COUNT
  } esc_e;

  cfg_t       cfg_q;
  esc_e       esc_q, esc_d;
  logic [7:0] run_left_q, run_left_d;
  logic [7:0] run_value_q, run_value_d;
  fmt_state_t fmt_q, fmt_d;
  fmt_state_t fmt_next;
  logic [7:0] fmt_byte;
  logic       do_fmt;
  logic       err;
  logic       pending;
  logic       busy;
  logic       load;
  burst_t     burst;
  logic [3:0] f_count;
  logic [23:0] f_data;
  logic       f_mono;
  logic       f_row_end;
  logic       f_image_end;
  logic [2:0] reg_idx;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[4:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width      <= 15'd1;
      cfg_q.image_height     <= 15'd1;
      cfg_q.depth_mode       <= DEPTH_INDEX;
      cfg_q.run_length_coded <= 1'b0;
      cfg_q.rgb_order        <= 1'b0;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_IMAGE_WIDTH:  cfg_q.image_width      <= pwdata[14:0];
        REG_IMAGE_HEIGHT: cfg_q.image_height     <= pwdata[14:0];
        REG_DEPTH_MODE:   cfg_q.depth_mode       <= pwdata[1:0];
        REG_RLE:          cfg_q.run_length_coded <= pwdata[0];
        REG_RGB_ORDER:    cfg_q.rgb_order        <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_IMAGE_WIDTH:  prdata = {17'd0, cfg_q.image_width};
      REG_IMAGE_HEIGHT: prdata = {17'd0, cfg_q.image_height};
      REG_DEPTH_MODE:   prdata = {30'd0, cfg_q.depth_mode};
      REG_RLE:          prdata = {31'd0, cfg_q.run_length_coded};
      REG_RGB_ORDER:    prdata = {31'd0, cfg_q.rgb_order};
      default:          prdata = '0;
    endcase
  end

  assign pending = (esc_q == ESC_IDLE) && (run_left_q != 8'd0);

  rrld_format #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_format (
    .cfg_i       (cfg_q),
    .st_i        (fmt_q),
    .byte_i      (fmt_byte),
    .st_o        (fmt_next),
    .count_o     (f_count),
    .data_o      (f_data),
    .mono_o      (f_mono),
    .row_end_o   (f_row_end),
    .image_end_o (f_image_end)
  );

  always_comb begin
    esc_d       = esc_q;
    run_left_d  = run_left_q;
    run_value_d = run_value_q;
    fmt_d       = fmt_q;
    err         = 1'b0;
    do_fmt      = 1'b0;
    fmt_byte    = data_byte_i;

    if (kind_i == KIND_START) begin
      esc_d       = ESC_IDLE;
      run_left_d  = '0;
      run_value_d = '0;
      fmt_d       = '0;
    end else if (kind_i == KIND_UNUSED || fmt_q.image_finished) begin
      err = 1'b1;
    end else if (kind_i == KIND_CONTINUE) begin
      if (!pending) begin
        err = 1'b1;
      end else begin
        run_left_d = run_left_q - 8'd1;
        fmt_byte   = run_value_q;
        do_fmt     = 1'b1;
      end
    end else if (pending) begin
      err = 1'b1;
    end else if (!cfg_q.run_length_coded) begin
      esc_d      = ESC_IDLE;
      run_left_d = '0;
      do_fmt     = 1'b1;
    end else begin
      case (esc_q)
        ESC_IDLE: begin
          if (data_byte_i == ESC_BYTE) begin
            esc_d = ESC_SEEN;
          end else begin
            do_fmt = 1'b1;
          end
        end
        ESC_SEEN: begin
          if (data_byte_i == 8'd0) begin
            esc_d    = ESC_IDLE;
            fmt_byte = ESC_BYTE;
            do_fmt   = 1'b1;
          end else begin
            run_left_d = data_byte_i;
            esc_d      = ESC_COUNT;
          end
        end
        ESC_COUNT: begin
          run_value_d = data_byte_i;
          esc_d       = ESC_IDLE;
          do_fmt      = 1'b1;
        end
        default: begin
          esc_d = ESC_IDLE;
        end
      endcase
    end

    if (do_fmt) begin
      fmt_d = fmt_next;
    end
  end

  always_comb begin
    burst                = '0;
    burst.run_pending    = (esc_d == ESC_IDLE) && (run_left_d != 8'd0);
    burst.protocol_error = err;
    if (do_fmt) begin
      burst.mono      = f_mono;
      burst.data      = f_data;
      burst.count     = f_count;
      burst.row_end   = f_row_end;
      burst.image_end = f_image_end;
    end
  end

  assign in_stall_o = busy;
  assign load       = in_valid_i && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q       <= ESC_IDLE;
      run_left_q  <= '0;
      run_value_q <= '0;
      fmt_q       <= '0;
    end else if (load) begin
      esc_q       <= esc_d;
      run_left_q  <= run_left_d;
      run_value_q <= run_value_d;
      fmt_q       <= fmt_d;
    end
  end

  rrld_out u_out (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (load),
    .burst_i          (burst),
    .busy_o           (busy),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pixel_valid_o    (pixel_valid_o),
    .pixel_o          (pixel_o),
    .row_end_o        (row_end_o),
    .image_end_o      (image_end_o),
    .run_pending_o    (run_pending_o),
    .protocol_error_o (protocol_error_o),
    .last_o           (last_o)
  );

endmodule

>>> rtl/core/rrld_format.sv
// Byte formatter: turns one decoded byte into pixels and the next row position.
module rrld_format import rrld_pkg::*; #(
  parameter int unsigned MAX_DIMENSION = MaxDimensionDefault
) (
  input  cfg_t        cfg_i,
  input  fmt_state_t  st_i,
  input  logic [7:0]  byte_i,
  output fmt_state_t  st_o,
  output logic [3:0]  count_o,
  output logic [23:0] data_o,
  output logic        mono_o,
  output logic        row_end_o,
  output logic        image_end_o
);

  function automatic logic [14:0] clamp_dim(input logic [14:0] v);
    logic [14:0] r;
    r = v;
    if (v == 15'd0) begin
      r = 15'd1;
    end else if (32'(v) > 32'(MAX_DIMENSION)) begin
      r = 15'(MAX_DIMENSION);
    end
    return r;
  endfunction

  logic [14:0] w;
  logic [14:0] h;
  logic [16:0] w17;
  logic [16:0] line_len;
  logic [17:0] row_span;
  logic        row_last;
  logic        col_ok;
  logic [15:0] room;
  logic        px_en;
  logic [23:0] px_data;
  logic [23:0] ca;

  assign w        = clamp_dim(cfg_i.image_width);
  assign h        = clamp_dim(cfg_i.image_height);
  assign w17      = {2'b00, w};
  assign row_last = ({1'b0, st_i.row_index} + 16'd1) >= {1'b0, h};
  assign col_ok   = st_i.pixel_column < w;
  assign room     = {1'b0, w} - {1'b0, st_i.pixel_column};

  always_comb begin
    case (cfg_i.depth_mode)
      DEPTH_MONO:  line_len = (w17 + 17'd7) >> 3;
      DEPTH_INDEX: line_len = w17;
      DEPTH_RGB24: line_len = (w17 << 1) + w17;
      default:     line_len = w17 << 2;
    endcase
  end

  assign row_span = {1'b0, line_len} + {17'd0, line_len[0]};

  always_comb begin
    st_o        = st_i;
    count_o     = '0;
    data_o      = '0;
    mono_o      = 1'b0;
    row_end_o   = 1'b0;
    image_end_o = 1'b0;
    px_en       = 1'b0;
    px_data     = '0;
    ca          = st_i.color_assembly;

    if (st_i.line_byte_index < line_len) begin
      case (cfg_i.depth_mode)
        DEPTH_MONO: begin
          mono_o = 1'b1;
          data_o = {16'd0, byte_i};
          if (col_ok) begin
            if (room >= 16'd8) begin
              count_o   = 4'd8;
              row_end_o = (room == 16'd8);
            end else begin
              count_o   = room[3:0];
              row_end_o = 1'b1;
            end
            image_end_o       = row_end_o && row_last;
            st_o.pixel_column = st_i.pixel_column + 15'(count_o);
          end
        end
        DEPTH_INDEX: begin
          px_en   = 1'b1;
          px_data = {16'd0, byte_i};
        end
        DEPTH_RGB24: begin
          if (cfg_i.rgb_order) begin
            case (st_i.byte_in_pixel)
              2'd0:    ca[23:16] = byte_i;
              2'd1:    ca[15:8]  = byte_i;
              default: ca[7:0]   = byte_i;
            endcase
          end else begin
            case (st_i.byte_in_pixel)
              2'd0:    ca[7:0]   = byte_i;
              2'd1:    ca[15:8]  = byte_i;
              default: ca[23:16] = byte_i;
            endcase
          end
          if (st_i.byte_in_pixel >= 2'd2) begin
            px_en               = 1'b1;
            px_data             = ca;
            st_o.color_assembly = '0;
            st_o.byte_in_pixel  = 2'd0;
          end else begin
            st_o.color_assembly = ca;
            st_o.byte_in_pixel  = st_i.byte_in_pixel + 2'd1;
          end
        end
        default: begin
          if (cfg_i.rgb_order) begin
            case (st_i.byte_in_pixel)
              2'd0:    ca[23:16] = byte_i;
              2'd1:    ca[15:8]  = byte_i;
              2'd2:    ca[7:0]   = byte_i;
              default: ca        = st_i.color_assembly;
            endcase
          end else begin
            case (st_i.byte_in_pixel)
              2'd1:    ca[7:0]   = byte_i;
              2'd2:    ca[15:8]  = byte_i;
              2'd3:    ca[23:16] = byte_i;
              default: ca        = st_i.color_assembly;
            endcase
          end
          if (st_i.byte_in_pixel == 2'd3) begin
            px_en               = 1'b1;
            px_data             = ca;
            st_o.color_assembly = '0;
            st_o.byte_in_pixel  = 2'd0;
          end else begin
            st_o.color_assembly = ca;
            st_o.byte_in_pixel  = st_i.byte_in_pixel + 2'd1;
          end
        end
      endcase

      if (px_en && col_ok) begin
        count_o           = 4'd1;
        data_o            = px_data;
        row_end_o         = (room == 16'd1);
        image_end_o       = row_end_o && row_last;
        st_o.pixel_column = st_i.pixel_column + 15'd1;
      end
    end

    st_o.line_byte_index = st_i.line_byte_index + 17'd1;
    if (({1'b0, st_i.line_byte_index} + 18'd1) >= row_span) begin
      st_o.line_byte_index = '0;
      st_o.pixel_column    = '0;
      st_o.byte_in_pixel   = 2'd0;
      st_o.color_assembly  = '0;
      st_o.row_index       = st_i.row_index + 15'd1;
      if (row_last) begin
        st_o.image_finished = 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/rrld_out.sv
// Result register and serializer that drains one burst a result per cycle when not stalled.
module rrld_out import rrld_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  burst_t      burst_i,
  output logic        busy_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        pixel_valid_o,
  output logic [23:0] pixel_o,
  output logic        row_end_o,
  output logic        image_end_o,
  output logic        run_pending_o,
  output logic        protocol_error_o,
  output logic        last_o
);

  logic   valid_q;
  logic   valid_d;
  burst_t burst_q;
  burst_t burst_d;
  logic   fire;
  logic   final_res;

  assign final_res = burst_q.count <= 4'd1;
  assign fire      = valid_q && !out_stall_i;
  assign busy_o    = valid_q && !(fire && final_res);

  always_comb begin
    valid_d = valid_q;
    burst_d = burst_q;
    if (load_i) begin
      valid_d = 1'b1;
      burst_d = burst_i;
    end else if (fire && final_res) begin
      valid_d = 1'b0;
    end else if (fire) begin
      burst_d.count = burst_q.count - 4'd1;
      burst_d.data  = {burst_q.data[22:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    burst_q <= burst_d;
  end

  assign out_valid_o      = valid_q;
  assign pixel_valid_o    = burst_q.count != 4'd0;
  assign pixel_o          = !pixel_valid_o ? 24'd0 :
                            burst_q.mono ? {23'd0, burst_q.data[7]} : burst_q.data;
  assign row_end_o        = pixel_valid_o && final_res && burst_q.row_end;
  assign image_end_o      = pixel_valid_o && final_res && burst_q.image_end;
  assign run_pending_o    = burst_q.run_pending;
  assign protocol_error_o = burst_q.protocol_error;
  assign last_o           = final_res;

endmodule

>>> rtl/core/rrld_checker.sv
// Port-level checks for the raster line decoder and their binding to the top level.
module rrld_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        pixel_valid_o,
  input logic [23:0] pixel_o,
  input logic        row_end_o,
  input logic        image_end_o,
  input logic        run_pending_o,
  input logic        protocol_error_o,
  input logic        last_o
);

  // A stalled result keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_o) && $stable(last_o)
      && $stable(pixel_valid_o))
    else $error("stalled result changed");

  // An ignored item yields a single empty result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && protocol_error_o |-> !pixel_valid_o && last_o)
    else $error("protocol error result carries a pixel");

  // The last pixel of the image also ends its row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && image_end_o |-> row_end_o && pixel_valid_o)
    else $error("image end without row end");

  // While a burst is still draining, no new input transfer is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("input taken while a burst is draining");

  // A burst that is not stalled continues with a further pixel in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o && !out_stall_i |=> out_valid_o && pixel_valid_o)
    else $error("burst broken off");

endmodule

bind raster_rle_line_decoder rrld_checker u_rrld_checker (.*);
